@@ rtl/core/r565aw_pkg.sv @@
// Shared types and constants for the RGB565 window writer.
// Used by every module under rtl/core; depends on nothing else.
package r565aw_pkg;

	localparam int COORD_WIDTH_DEF = 10;
	localparam int COORD_MAX_W     = 16;
	localparam int QUEUE_DEPTH     = 2;

	localparam int RIGHT_RESET  = 479;
	localparam int BOTTOM_RESET = 319;

	localparam logic [7:0] CMD_COLUMN = 8'h2A;
	localparam logic [7:0] CMD_PAGE   = 8'h2B;
	localparam logic [7:0] CMD_WRITE  = 8'h2C;

	localparam int          CFG_INDEX_W = 3;
	localparam logic [2:0] REG_LEFT    = 3'd0;
	localparam logic [2:0] REG_RIGHT   = 3'd1;
	localparam logic [2:0] REG_TOP     = 3'd2;
	localparam logic [2:0] REG_BOTTOM  = 3'd3;
	localparam logic [2:0] REG_SWAP    = 3'd4;

	// one byte slot of the per-pixel output sequence
	typedef enum logic [3:0] {
		ST_CMD_COL  = 4'd0,
		ST_LEFT_HI  = 4'd1,
		ST_LEFT_LO  = 4'd2,
		ST_RIGHT_HI = 4'd3,
		ST_RIGHT_LO = 4'd4,
		ST_CMD_PAGE = 4'd5,
		ST_Y0_HI    = 4'd6,
		ST_Y0_LO    = 4'd7,
		ST_Y1_HI    = 4'd8,
		ST_Y1_LO    = 4'd9,
		ST_CMD_WR   = 4'd10,
		ST_RED      = 4'd11,
		ST_GREEN    = 4'd12,
		ST_BLUE     = 4'd13
	} step_t;

	// classified pixel request handed from front to back
	typedef struct packed {
		logic                   header;
		logic [COORD_MAX_W-1:0] left;
		logic [COORD_MAX_W-1:0] right;
		logic [COORD_MAX_W-1:0] row;
		logic [7:0]             red;
		logic [7:0]             green;
		logic [7:0]             blue;
		logic                   row_end;
		logic                   area_end;
	} entry_t;

endpackage

@@ rtl/core/rgb565_area_to_rgb888_spi_stream_unit.sv @@
// RGB565 window writer top level: configuration registers, front end, queue, sequencer.
// Depends on r565aw_pkg, r565aw_front, r565aw_queue, r565aw_back.
//
// Takes one RGB565 pixel per request on s_* for the configured window, row by row,
// and emits display bytes on m_*: at the first pixel of a row the column/page/write
// sequence (11 bytes) followed by R, G, B, otherwise R, G, B alone. The byte
// sequencer sends one byte per cycle unless m_tready stalls it; that sequencer
// sets the throughput. Pixels are classified on acceptance and held in a
// two-entry queue, so s_tready stays high while the sequencer is busy until the
// queue fills. Output bytes come from a register; a pixel passes through the
// queue and then that output register before its first byte appears. Write the
// window registers only while no pixel is in flight; cfg_ready is always high.
module rgb565_area_to_rgb888_spi_stream_unit #(
	parameter int COORD_WIDTH = r565aw_pkg::COORD_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [r565aw_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [COORD_WIDTH-1:0]               cfg_data,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [15:0]                          s_tdata,  // [15:0] pixel
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [7:0]                           m_tdata,  // [7:0] out_byte
	output logic                                 m_tlast,  // last_of_item
	output logic [2:0]                           m_tuser   // [0] is_data, [1] end_of_transfer,
	                                                       // [2] area_done
);
	import r565aw_pkg::*;

	logic [COORD_WIDTH-1:0] left_q;
	logic [COORD_WIDTH-1:0] right_q;
	logic [COORD_WIDTH-1:0] top_q;
	logic [COORD_WIDTH-1:0] bottom_q;
	logic                   swap_q;
	logic                   push;
	entry_t                 push_entry;
	logic                   queue_full;
	logic                   not_empty;
	logic                   pop;
	entry_t                 head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			right_q  <= COORD_WIDTH'(RIGHT_RESET);
			top_q    <= '0;
			bottom_q <= COORD_WIDTH'(BOTTOM_RESET);
			swap_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LEFT:   left_q   <= cfg_data;
				REG_RIGHT:  right_q  <= cfg_data;
				REG_TOP:    top_q    <= cfg_data;
				REG_BOTTOM: bottom_q <= cfg_data;
				REG_SWAP:   swap_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	r565aw_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.area_left  (left_q),
		.area_right (right_q),
		.area_top   (top_q),
		.area_bottom(bottom_q),
		.swap_bytes (swap_q),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.queue_full (queue_full),
		.push       (push),
		.push_entry (push_entry)
	);

	r565aw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.full      (queue_full),
		.not_empty (not_empty),
		.head      (head)
	);

	r565aw_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.not_empty(not_empty),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

@@ rtl/core/r565aw_front.sv @@
// Front end: accepts pixels, tracks the window position, converts RGB565 to RGB888.
// Depends on r565aw_pkg.
module r565aw_front #(
	parameter int COORD_WIDTH = r565aw_pkg::COORD_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [COORD_WIDTH-1:0]  area_left,
	input  logic [COORD_WIDTH-1:0]  area_right,
	input  logic [COORD_WIDTH-1:0]  area_top,
	input  logic [COORD_WIDTH-1:0]  area_bottom,
	input  logic                    swap_bytes,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [15:0]             s_tdata,  // [15:0] pixel
	input  logic                    queue_full,
	output logic                    push,
	output r565aw_pkg::entry_t      push_entry
);
	import r565aw_pkg::*;

	logic [COORD_WIDTH-1:0] col_off_q;
	logic [COORD_WIDTH-1:0] row_off_q;
	logic [COORD_WIDTH:0]   col_sum;
	logic [COORD_WIDTH:0]   row_sum;
	logic                   row_end;
	logic                   area_end;
	logic [15:0]            pix;
	logic [4:0]             r5;
	logic [5:0]             g6;
	logic [4:0]             b5;

	assign s_tready = !queue_full;
	assign push     = s_tvalid && s_tready;

	// sums keep the carry, the end tests are not modulo
	assign col_sum  = {1'b0, area_left} + {1'b0, col_off_q};
	assign row_sum  = {1'b0, area_top} + {1'b0, row_off_q};
	assign row_end  = col_sum >= {1'b0, area_right};
	assign area_end = row_end && (row_sum >= {1'b0, area_bottom});

	assign pix = swap_bytes ? {s_tdata[7:0], s_tdata[15:8]} : s_tdata;
	assign r5  = pix[15:11];
	assign g6  = pix[10:5];
	assign b5  = pix[4:0];

	always_comb begin
		push_entry.header   = (col_off_q == '0);
		push_entry.left     = COORD_MAX_W'(area_left);
		push_entry.right    = COORD_MAX_W'(area_right);
		push_entry.row      = COORD_MAX_W'(row_sum[COORD_WIDTH-1:0]);
		push_entry.red      = {r5, r5[4:2]};
		push_entry.green    = {g6, g6[5:4]};
		push_entry.blue     = {b5, b5[4:2]};
		push_entry.row_end  = row_end;
		push_entry.area_end = area_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_off_q <= '0;
			row_off_q <= '0;
		end else if (push) begin
			if (area_end) begin
				col_off_q <= '0;
				row_off_q <= '0;
			end else if (row_end) begin
				col_off_q <= '0;
				row_off_q <= row_off_q + COORD_WIDTH'(1);
			end else begin
				col_off_q <= col_off_q + COORD_WIDTH'(1);
			end
		end
	end

endmodule

@@ rtl/core/r565aw_queue.sv @@
// Short request queue between front end and byte sequencer.
// Depends on r565aw_pkg.
module r565aw_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  r565aw_pkg::entry_t push_entry,
	input  logic               pop,
	output logic               full,
	output logic               not_empty,
	output r565aw_pkg::entry_t head
);
	import r565aw_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;

	assign full      = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue pop while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

@@ rtl/core/r565aw_back.sv @@
// Byte sequencer: walks each queued request through window commands and RGB bytes.
// Depends on r565aw_pkg.
module r565aw_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               not_empty,
	input  r565aw_pkg::entry_t head,
	output logic               pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,  // [7:0] out_byte
	output logic               m_tlast,  // last_of_item
	output logic [2:0]         m_tuser   // [0] is_data, [1] end_of_transfer, [2] area_done
);
	import r565aw_pkg::*;

	step_t      step_q;
	step_t      step;
	logic       load;
	logic [7:0] byte_d;
	logic       data_d;
	logic       eot_d;
	logic       last_d;
	logic       done_d;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_data_q;
	logic       out_eot_q;
	logic       out_last_q;
	logic       out_done_q;

	// a request without header starts straight at the pixel bytes
	assign step = (step_q == ST_CMD_COL && !head.header) ? ST_RED : step_q;
	assign load = !out_valid_q || m_tready;
	assign pop  = load && not_empty && (step == ST_BLUE);

	always_comb begin
		byte_d = '0;
		data_d = 1'b1;
		eot_d  = 1'b0;
		last_d = 1'b0;
		done_d = 1'b0;
		case (step)
			ST_CMD_COL: begin
				byte_d = CMD_COLUMN;
				data_d = 1'b0;
				eot_d  = 1'b1;
			end
			ST_LEFT_HI:  byte_d = head.left[15:8];
			ST_LEFT_LO:  byte_d = head.left[7:0];
			ST_RIGHT_HI: byte_d = head.right[15:8];
			ST_RIGHT_LO: begin
				byte_d = head.right[7:0];
				eot_d  = 1'b1;
			end
			ST_CMD_PAGE: begin
				byte_d = CMD_PAGE;
				data_d = 1'b0;
				eot_d  = 1'b1;
			end
			ST_Y0_HI:    byte_d = head.row[15:8];
			ST_Y0_LO:    byte_d = head.row[7:0];
			ST_Y1_HI:    byte_d = head.row[15:8];
			ST_Y1_LO: begin
				byte_d = head.row[7:0];
				eot_d  = 1'b1;
			end
			ST_CMD_WR: begin
				byte_d = CMD_WRITE;
				data_d = 1'b0;
				eot_d  = 1'b1;
			end
			ST_RED:      byte_d = head.red;
			ST_GREEN:    byte_d = head.green;
			ST_BLUE: begin
				byte_d = head.blue;
				eot_d  = head.row_end;
				last_d = 1'b1;
				done_d = head.area_end;
			end
			default: begin
				byte_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_CMD_COL;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= not_empty;
			if (not_empty) begin
				step_q <= (step == ST_BLUE) ? ST_CMD_COL : step_t'(step + 4'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && not_empty) begin
			out_byte_q <= byte_d;
			out_data_q <= data_d;
			out_eot_q  <= eot_d;
			out_last_q <= last_d;
			out_done_q <= done_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = {out_done_q, out_eot_q, out_data_q};

	a_done_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[2]) |-> m_tlast && m_tuser[1])
		else $error("area_done without last byte of pixel");

	a_cmd_releases_cs: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> m_tuser[1] && !m_tlast)
		else $error("command byte without chip select release");

	a_pop_with_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> m_tvalid && m_tlast)
		else $error("request retired without its final byte");

endmodule

@@ tb/sv/rgb565_area_to_rgb888_spi_stream_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for rgb565_area_to_rgb888_spi_stream_unit: a directed table, then random
// windows and pixels under several idle/stall mixes, each byte checked against a local predictor.
// Depends on r565aw_pkg and the RTL under rtl/core.
module rgb565_area_to_rgb888_spi_stream_unit_tb;
	import r565aw_pkg::*;

	localparam int COORD_W     = COORD_WIDTH_DEF;
	localparam int COORD_TOP   = (1 << COORD_W) - 1;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;
	localparam int LAT_CYCLES  = 4;
	localparam int HOLD_LEN    = 400;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES      = 4;
	localparam int BATCHES     = 4;
	localparam int BATCH_ITEMS = 27;

	// one byte on the display link, with its flags
	typedef struct packed {
		logic [7:0] data;
		logic       is_data;
		logic       eot;
		logic       last;
		logic       done;
	} link_byte_t;

	typedef struct {
		logic                   is_cfg;
		logic [CFG_INDEX_W-1:0] idx;
		logic [15:0]            val;
		logic                   has_rgb;
		logic [23:0]            rgb;
	} dir_row_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [COORD_W-1:0]     cfg_data  = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [15:0]            s_tdata   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [7:0]             m_tdata;
	logic                   m_tlast;
	logic [2:0]             m_tuser;

	// predictor copy of the window registers and walk position
	logic [COORD_W-1:0] win_left   = '0;
	logic [COORD_W-1:0] win_right  = COORD_W'(RIGHT_RESET);
	logic [COORD_W-1:0] win_top    = '0;
	logic [COORD_W-1:0] win_bottom = COORD_W'(BOTTOM_RESET);
	logic               win_swap   = 1'b0;
	logic [COORD_W-1:0] col_off    = '0;
	logic [COORD_W-1:0] row_off    = '0;

	link_byte_t byte_q[$];
	dir_row_t   dir_rows[$];
	int         mismatch_cnt = 0;
	int         cycle_cnt    = 0;
	int         src_idle     = 0;
	int         sink_stall   = 0;
	logic       src_held     = 1'b0;
	logic       cfg_held     = 1'b0;
	logic       hold_go      = 1'b0;
	logic       hold_done    = 1'b0;
	int         hold_cnt     = 0;
	logic       sink_hold;

	rgb565_area_to_rgb888_spi_stream_unit #(
		.COORD_WIDTH(COORD_W)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// long receiver hold-off, started once by the stimulus
	assign sink_hold = hold_go && !hold_done;

	always @(posedge clk) begin
		if (sink_hold) begin
			if (hold_cnt == HOLD_LEN)
				hold_done <= 1'b1;
			else
				hold_cnt <= hold_cnt + 1;
		end
	end

	always @(posedge clk) begin
		m_tready <= !sink_hold && ($urandom_range(0, 99) >= sink_stall);
	end

	function automatic void report_mismatch(input string what, input link_byte_t want,
	                                        input link_byte_t got);
		mismatch_cnt++;
		if (mismatch_cnt <= 10) begin
			$write("%0t %s: exp byte=%02h dat=%b eot=%b last=%b done=%b,",
			       $realtime, what, want.data, want.is_data, want.eot, want.last, want.done);
			$display(" got byte=%02h dat=%b eot=%b last=%b done=%b",
			         got.data, got.is_data, got.eot, got.last, got.done);
		end
	endfunction

	always @(posedge clk) begin : check_out
		link_byte_t want;
		link_byte_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata, m_tuser[0], m_tuser[1], m_tlast, m_tuser[2]};
			if (byte_q.size() == 0) begin
				report_mismatch("byte with nothing expected", '0, got);
			end else begin
				want = byte_q.pop_front();
				if (want !== got)
					report_mismatch("byte mismatch", want, got);
			end
		end
	end

	function automatic void queue_byte(input logic [7:0] d, input logic dat, input logic eot);
		link_byte_t b;
		b = {d, dat, eot, 1'b0, 1'b0};
		byte_q.push_back(b);
	endfunction

	function automatic void queue_coord_pair(input logic [COORD_W-1:0] a,
	                                         input logic [COORD_W-1:0] b);
		logic [15:0] wa;
		logic [15:0] wb;
		wa = 16'(a);
		wb = 16'(b);
		queue_byte(wa[15:8], 1'b1, 1'b0);
		queue_byte(wa[7:0], 1'b1, 1'b0);
		queue_byte(wb[15:8], 1'b1, 1'b0);
		queue_byte(wb[7:0], 1'b1, 1'b1);
	endfunction

	// expected bytes for one accepted pixel, then advance the walk
	function automatic void predict_pixel(input logic [15:0] px);
		int unsigned        col;
		int unsigned        row;
		logic               row_end;
		logic               area_end;
		logic [15:0]        c;
		logic [4:0]         red;
		logic [5:0]         green;
		logic [4:0]         blue;
		logic [COORD_W-1:0] y;
		// end tests use the unwrapped sums
		col = win_left + col_off;
		row = win_top + row_off;
		row_end = col >= win_right;
		area_end = row_end && (row >= win_bottom);
		if (col_off == '0) begin
			y = row[COORD_W-1:0];
			queue_byte(CMD_COLUMN, 1'b0, 1'b1);
			queue_coord_pair(win_left, win_right);
			queue_byte(CMD_PAGE, 1'b0, 1'b1);
			queue_coord_pair(y, y);
			queue_byte(CMD_WRITE, 1'b0, 1'b1);
		end
		c = win_swap ? {px[7:0], px[15:8]} : px;
		red = c[15:11];
		green = c[10:5];
		blue = c[4:0];
		queue_byte({red, red[4:2]}, 1'b1, 1'b0);
		queue_byte({green, green[5:4]}, 1'b1, 1'b0);
		queue_byte({blue, blue[4:2]}, 1'b1, row_end);
		byte_q[byte_q.size()-1].last = 1'b1;
		byte_q[byte_q.size()-1].done = area_end;
		if (area_end) begin
			col_off = '0;
			row_off = '0;
		end else if (row_end) begin
			col_off = '0;
			row_off = row_off + 1'b1;
		end else begin
			col_off = col_off + 1'b1;
		end
	endfunction

	task automatic release_cfg();
		if (cfg_held) begin
			cfg_valid <= 1'b0;
			cfg_held = 1'b0;
		end
	endtask

	task automatic release_src();
		if (src_held) begin
			s_tvalid <= 1'b0;
			src_held = 1'b0;
		end
	endtask

	// valid stays high after the write so back-to-back writes need no gap
	task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [COORD_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		cfg_held = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_LEFT:   win_left = val;
			REG_RIGHT:  win_right = val;
			REG_TOP:    win_top = val;
			REG_BOTTOM: win_bottom = val;
			REG_SWAP:   win_swap = val[0];
			default: ;
		endcase
	endtask

	task automatic push_pixel(input logic [15:0] px);
		release_cfg();
		while ($urandom_range(0, 99) < src_idle) begin
			s_tvalid <= 1'b0;
			src_held = 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= px;
		src_held = 1'b1;
		do @(posedge clk); while (!s_tready);
		predict_pixel(px);
	endtask

	task automatic wait_idle();
		release_src();
		release_cfg();
		while (byte_q.size() != 0)
			@(posedge clk);
		repeat (LAT_CYCLES) @(posedge clk);
	endtask

	task automatic rand_window();
		int unsigned mode;
		int unsigned w;
		int unsigned h;
		int unsigned l;
		int unsigned r;
		int unsigned t;
		int unsigned b;
		mode = $urandom_range(0, 7);
		w = $urandom_range(0, 5);
		h = $urandom_range(0, 3);
		l = $urandom_range(0, COORD_TOP - w);
		r = l + w;
		t = $urandom_range(0, COORD_TOP - h);
		b = t + h;
		case (mode)
			0: begin
				l = $urandom_range(1, COORD_TOP);
				r = $urandom_range(0, l - 1);
			end
			1: begin
				t = $urandom_range(1, COORD_TOP);
				b = $urandom_range(0, t - 1);
			end
			2: begin
				l = $urandom_range(0, 1) * COORD_TOP;
				r = $urandom_range(0, 1) * COORD_TOP;
				t = $urandom_range(0, 1) * COORD_TOP;
				b = $urandom_range(0, 1) * COORD_TOP;
			end
			default: ;
		endcase
		cfg_write(REG_LEFT, COORD_W'(l));
		cfg_write(REG_RIGHT, COORD_W'(r));
		cfg_write(REG_TOP, COORD_W'(t));
		cfg_write(REG_BOTTOM, COORD_W'(b));
		cfg_write(REG_SWAP, COORD_W'($urandom_range(0, COORD_TOP)));
		if ($urandom_range(0, 3) == 0)
			cfg_write(CFG_INDEX_W'($urandom_range(REG_SWAP + 1, REG_SPARE)),
			          COORD_W'($urandom()));
	endtask

	function automatic void add_pix(input logic [15:0] px, input logic has, input logic [23:0] rgb);
		dir_row_t row;
		row = '{1'b0, REG_LEFT, px, has, rgb};
		dir_rows.push_back(row);
	endfunction

	function automatic void add_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
		dir_row_t row;
		row = '{1'b1, idx, val, 1'b0, 24'h0};
		dir_rows.push_back(row);
	endfunction

	initial begin
		logic [15:0] px;
		int          n;

		// reset window: first pixel opens row 0 of 0..479 x 0..319
		add_pix(16'h0000, 1'b1, 24'h000000);
		add_pix(16'hFFFF, 1'b1, 24'hFFFFFF);
		add_pix(16'hF800, 1'b1, 24'hFF0000);
		add_pix(16'h07E0, 1'b1, 24'h00FF00);
		add_pix(16'h001F, 1'b1, 24'h0000FF);
		add_pix(16'h0821, 1'b0, 24'h0);
		// 2x2 window in the far corner, bytes swapped; the walk carries over from the
		// unfinished reset window
		add_cfg(REG_LEFT, 16'd1022);
		add_cfg(REG_RIGHT, 16'd1023);
		add_cfg(REG_TOP, 16'd1022);
		add_cfg(REG_BOTTOM, 16'd1023);
		add_cfg(REG_SWAP, 16'd1);
		add_pix(16'h00FF, 1'b1, 24'hFFE300);
		add_pix(16'hA5C3, 1'b0, 24'h0);
		add_pix(16'h1234, 1'b0, 24'h0);
		add_pix(16'hFFFF, 1'b1, 24'hFFFFFF);
		add_pix(16'h0000, 1'b1, 24'h000000);
		// swap cleared by bit 0 only; spare index ignored; columns inverted
		add_cfg(REG_SWAP, 16'h03FE);
		add_cfg(REG_SPARE, 16'h03FF);
		add_cfg(REG_LEFT, 16'd5);
		add_cfg(REG_RIGHT, 16'd2);
		add_cfg(REG_TOP, 16'd0);
		add_cfg(REG_BOTTOM, 16'd1023);
		add_pix(16'h1357, 1'b0, 24'h0);
		add_pix(16'h2468, 1'b0, 24'h0);
		// rows inverted: window ends at the end of the current row
		add_cfg(REG_LEFT, 16'd0);
		add_cfg(REG_RIGHT, 16'd1);
		add_cfg(REG_TOP, 16'd9);
		add_cfg(REG_BOTTOM, 16'd3);
		add_pix(16'h8000, 1'b0, 24'h0);
		add_pix(16'h0001, 1'b0, 24'h0);
		// finish one row, then move the top mid window so the row number wraps
		add_cfg(REG_RIGHT, 16'd2);
		add_cfg(REG_TOP, 16'd0);
		add_cfg(REG_BOTTOM, 16'd10);
		add_pix(16'h5A5A, 1'b0, 24'h0);
		add_pix(16'hA5A5, 1'b0, 24'h0);
		add_pix(16'h7BEF, 1'b0, 24'h0);
		add_cfg(REG_TOP, 16'd1023);
		add_pix(16'h8410, 1'b0, 24'h0);
		add_pix(16'hC618, 1'b0, 24'h0);
		add_pix(16'h39E7, 1'b0, 24'h0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				if (!cfg_held)
					wait_idle();
				cfg_write(dir_rows[i].idx, COORD_W'(dir_rows[i].val));
			end else begin
				push_pixel(dir_rows[i].val);
				if (dir_rows[i].has_rgb) begin
					n = byte_q.size();
					byte_q[n-3].data = dir_rows[i].rgb[23:16];
					byte_q[n-2].data = dir_rows[i].rgb[15:8];
					byte_q[n-1].data = dir_rows[i].rgb[7:0];
				end
			end
		end

		// phases: no idling, sender idle, receiver stalling, both
		for (int ph = 0; ph < PHASES; ph++) begin
			src_idle = (ph == 1) ? 77 : (ph == 3) ? 26 : 0;
			sink_stall <= (ph == 2) ? 77 : (ph == 3) ? 26 : 0;
			for (int bt = 0; bt < BATCHES; bt++) begin
				wait_idle();
				rand_window();
				// receiver goes quiet while requests keep coming
				if (ph == 0 && bt == 1)
					hold_go <= 1'b1;
				for (int k = 0; k < BATCH_ITEMS; k++) begin
					case ($urandom_range(0, 9))
						0:       px = 16'h0000;
						1:       px = 16'hFFFF;
						default: px = 16'($urandom_range(0, 16'hFFFF));
					endcase
					push_pixel(px);
				end
			end
		end

		wait_idle();
		if (mismatch_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
